FILE: rtl/fdr_pkg.sv
`timescale 1ns / 1ps
package fdr_pkg;

    localparam int TableEntries = 1024;
    localparam int KeyW = $clog2(TableEntries);

    // Round a positive normal double to single precision, nearest even.
    function automatic logic [31:0] dbl_to_flt(input real v);
        logic [63:0] d;
        logic [30:0] body;
        logic        rnd;
        logic        stk;
        logic [10:0] de;
        begin
            d    = $realtobits(v);
            de   = d[62:52];
            body = {8'(de - 11'd896), d[51:29]};
            rnd  = d[28];
            stk  = |d[27:0];
            if (rnd && (stk || body[0])) begin
                body = body + 31'd1;
            end
            dbl_to_flt = {d[63], body};
        end
    endfunction

endpackage

FILE: rtl/fdr_rom.sv
`timescale 1ns / 1ps
module fdr_rom
    import fdr_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [KeyW-1:0] i_key,
    output logic [63:0]     o_word
);
    logic [63:0] rom_w [TableEntries];
    logic [63:0] r_word;

    // Slope in the high word, intercept in the low word; each entry is worked out
    // in double and rounded to single.
    for (genvar g = 0; g < TableEntries; g++) begin : g_ent
        localparam real NumE   = real'(TableEntries);
        localparam real Idx    = real'(g);
        localparam real SlopeR = NumE * (NumE / (NumE + Idx) - NumE / (NumE + 1.0 + Idx));
        localparam real IceptR = NumE * (1.0 - (NumE + Idx) / (NumE + 1.0 + Idx))
            + (768.0 / (NumE + Idx) - 256.0 / (NumE + 1.0 + Idx)
               + 1024.0 / (2.0 * NumE + 1.0 + 2.0 * Idx));
        localparam logic [63:0] Word = {dbl_to_flt(SlopeR), dbl_to_flt(IceptR)};
        assign rom_w[g] = Word;
    end

    // Registered read of the slope/intercept table.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= rom_w[i_key];
        end
    end

    assign o_word = r_word;
endmodule

FILE: rtl/fdr_fsub.sv
`timescale 1ns / 1ps
module fdr_fsub
    import fdr_pkg::*;
(
    input  logic [23:0] i_mb,
    input  logic [8:0]  i_eb,
    input  logic [23:0] i_mc,
    input  logic [8:0]  i_ec,
    output logic [22:0] o_frac
);
    logic        swap;
    logic [23:0] mh;
    logic [23:0] ml;
    logic [8:0]  dexp;
    logic [49:0] big;
    logic [49:0] lit;
    logic [49:0] sh;
    logic        stk;
    logic [49:0] diff;
    logic [5:0]  lz;
    logic [49:0] nrm;
    logic [24:0] mr;

    always_comb begin
        swap = (i_ec > i_eb) || ((i_ec == i_eb) && (i_mc > i_mb));
        mh   = swap ? i_mc : i_mb;
        ml   = swap ? i_mb : i_mc;
        dexp = swap ? (i_ec - i_eb) : (i_eb - i_ec);
        big  = {mh, 26'd0};
        lit  = {ml, 26'd0};
        if (dexp >= 9'd50) begin
            sh  = '0;
            stk = |ml;
        end else begin
            sh  = lit >> dexp[5:0];
            stk = |(lit & ((50'd1 << dexp[5:0]) - 50'd1));
        end
        diff = big - sh - {49'd0, stk};
        // Leading-one search over the difference.
        lz = '0;
        for (int i = 0; i < 50; i++) begin
            if (diff[i]) begin
                lz = 6'(49 - i);
            end
        end
        nrm = diff << lz;
        mr  = {1'b0, nrm[49:26]};
        if (nrm[25] && ((|nrm[24:0]) || nrm[26])) begin
            mr = mr + 25'd1;
        end
        o_frac = mr[24] ? 23'd0 : mr[22:0];
    end
endmodule

FILE: rtl/float32_divide_table_reciprocal_unit.sv
`timescale 1ns / 1ps
// Single-precision divider built on a linear reciprocal table.
// Six register stages; a result is presented on m_tvalid/m_tdata from the stage-6 register.
// Throughput: one item per cycle unless m_tready stalls; each stage advances when it is empty or its
// successor advances, so stalls close bubbles and lose nothing.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; the table is constant.
module float32_divide_table_reciprocal_unit
    import fdr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] dividend_bits, [63:32] divisor_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] quotient_bits
);
    // Stage valids and advance enables.
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    logic a1, a2, a3, a4, a5, a6;

    // Payload registers.
    logic [31:0] r1_x1, r2_x1, r3_x1, r4_x1, r5_x1;
    logic [8:0]  r1_e2, r2_e2, r3_e2, r4_e2, r5_e2;   // sign and exponent of divisor
    logic [22:0] r1_m2;
    logic [47:0] r2_p;
    logic [7:0]  r2_ea;
    logic [31:0] r2_b, r3_b;
    logic [23:0] r3_mc;
    logic [8:0]  r3_ec;
    logic [22:0] r4_m3;
    logic [47:0] r5_p;
    logic [31:0] r6_q;

    logic [63:0] rom_word;
    logic [47:0] n_p2;
    logic [23:0] n_mc;
    logic [8:0]  n_ec;
    logic [22:0] n_m3;
    logic [47:0] n_p5;
    logic [31:0] n_q;

    // Advance chain from the output back to the input.
    assign a6 = !r6_v || m_tready;
    assign a5 = !r5_v || a6;
    assign a4 = !r4_v || a5;
    assign a3 = !r3_v || a4;
    assign a2 = !r2_v || a3;
    assign a1 = !r1_v || a2;
    assign s_tready = a1;

    // Stage 1: table lookup on the top ten divisor fraction bits.
    fdr_rom u_rom (
        .i_clk (i_clk),
        .i_en  (a1),
        .i_key (s_tdata[54:45]),
        .o_word(rom_word)
    );

    // Stage 2: slope times 1.m2, full product.
    assign n_p2 = {1'b1, rom_word[54:32]} * {1'b1, r1_m2};

    // Stage 3: round the product to single precision, nearest even.
    always_comb begin
        logic [24:0] m;
        logic        g;
        logic        st;
        if (r2_p[47]) begin
            m  = {1'b0, r2_p[47:24]};
            g  = r2_p[23];
            st = |r2_p[22:0];
        end else begin
            m  = {1'b0, r2_p[46:23]};
            g  = r2_p[22];
            st = |r2_p[21:0];
        end
        if (g && (st || m[0])) begin
            m = m + 25'd1;
        end
        n_ec = {1'b0, r2_ea} + {8'd0, r2_p[47]} + {8'd0, m[24]};
        n_mc = m[24] ? 24'h800000 : m[23:0];
    end

    // Stage 4: intercept minus scaled divisor, rounded.
    fdr_fsub u_fsub (
        .i_mb  ({1'b1, r3_b[22:0]}),
        .i_eb  ({1'b0, r3_b[30:23]}),
        .i_mc  (r3_mc),
        .i_ec  (r3_ec),
        .o_frac(n_m3)
    );

    // Stage 5: 1.m1 times reciprocal mantissa.
    assign n_p5 = {1'b1, r4_x1[22:0]} * {1'b1, r4_m3};

    // Stage 6: normalize, exponent, flush to zero or infinity.
    always_comb begin
        logic        cy;
        logic [22:0] fr;
        logic [9:0]  eq;
        logic [7:0]  e1;
        logic [7:0]  e2;
        logic        udf;
        logic        ovf;
        cy  = r5_p[47];
        fr  = cy ? r5_p[46:24] : r5_p[45:23];
        e1  = r5_x1[30:23];
        e2  = r5_e2[7:0];
        eq  = {2'b0, e1} - {2'b0, e2} + 10'd126 + {9'd0, cy};
        udf = (e1 == 8'd0) || (e2 == 8'hFF) || eq[9] || (eq == 10'd0);
        ovf = (e1 == 8'hFF) || (e2 == 8'd0) || (eq >= 10'd255);
        if (udf) begin
            n_q = {r5_x1[31] ^ r5_e2[8], 31'd0};
        end else if (ovf) begin
            n_q = {r5_x1[31] ^ r5_e2[8], 8'hFF, 23'd0};
        end else begin
            n_q = {r5_x1[31] ^ r5_e2[8], eq[7:0], fr};
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            if (a1) r1_v <= s_tvalid;
            if (a2) r2_v <= r1_v;
            if (a3) r3_v <= r2_v;
            if (a4) r4_v <= r3_v;
            if (a5) r5_v <= r4_v;
            if (a6) r6_v <= r5_v;
        end
    end

    // Payload: advance with the stage, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (a1) begin
            r1_x1 <= s_tdata[31:0];
            r1_e2 <= {s_tdata[63], s_tdata[62:55]};
            r1_m2 <= s_tdata[54:32];
        end
        if (a2) begin
            r2_x1 <= r1_x1;
            r2_e2 <= r1_e2;
            r2_p  <= n_p2;
            r2_ea <= rom_word[62:55];
            r2_b  <= rom_word[31:0];
        end
        if (a3) begin
            r3_x1 <= r2_x1;
            r3_e2 <= r2_e2;
            r3_b  <= r2_b;
            r3_mc <= n_mc;
            r3_ec <= n_ec;
        end
        if (a4) begin
            r4_x1 <= r3_x1;
            r4_e2 <= r3_e2;
            r4_m3 <= n_m3;
        end
        if (a5) begin
            r5_x1 <= r4_x1;
            r5_e2 <= r4_e2;
            r5_p  <= n_p5;
        end
        if (a6) begin
            r6_q <= n_q;
        end
    end

    assign m_tvalid = r6_v;
    assign m_tdata  = r6_q;

    // A zero exponent always carries a zero fraction.
    a_zero_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tdata[30:23] == 8'd0) |-> (m_tdata[22:0] == 23'd0))
        else $error("zero exponent with nonzero fraction");

    // Infinity always carries a zero fraction.
    a_inf_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tdata[30:23] == 8'hFF) |-> (m_tdata[22:0] == 23'd0))
        else $error("infinity with nonzero fraction");

    // Input backpressure only when every stage is occupied.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (r1_v && r2_v && r3_v && r4_v && r5_v && r6_v))
        else $error("stall with a bubble in the pipeline");
endmodule
